// ===== sv/sitda_pkg.sv =====
package sitda_pkg;

  // ASCII codes of the characters in a run
  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [6:0] CH_NL    = 7'd10;

  // Double-dabble correction: add 3 to any BCD digit of 5 or more before a shift
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_DIGIT,
    ST_NL
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CONV,
    OP_SIGN,
    OP_SKIP,
    OP_DIGIT,
    OP_NL
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic neg;        // value being printed is negative
    logic conv_last;  // last magnitude bit is being shifted in
    logic top_zero;   // leading BCD digit is zero
    logic dig_last;   // one digit left to print
    logic out_free;   // output register can take a character this cycle
  } sts_t;

endpackage

// ===== sv/sitda_ctrl.sv =====
module sitda_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sitda_pkg::sts_t sts_i,
  output sitda_pkg::cmd_t cmd_o
);

  sitda_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o.op   = sitda_pkg::OP_NONE;
    unique case (state_q)
      sitda_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = sitda_pkg::OP_LOAD;
          state_d  = sitda_pkg::ST_CONV;
        end
      end
      sitda_pkg::ST_CONV: begin
        cmd_o.op = sitda_pkg::OP_CONV;
        if (sts_i.conv_last) begin
          state_d = sitda_pkg::ST_SIGN;
        end
      end
      sitda_pkg::ST_SIGN: begin
        if (!sts_i.neg) begin
          state_d = sitda_pkg::ST_SKIP;
        end else if (sts_i.out_free) begin
          cmd_o.op = sitda_pkg::OP_SIGN;
          state_d  = sitda_pkg::ST_SKIP;
        end
      end
      sitda_pkg::ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (sts_i.top_zero && !sts_i.dig_last) begin
          cmd_o.op = sitda_pkg::OP_SKIP;
        end else begin
          state_d = sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = sitda_pkg::OP_DIGIT;
          if (sts_i.dig_last) begin
            state_d = sitda_pkg::ST_NL;
          end
        end
      end
      sitda_pkg::ST_NL: begin
        if (sts_i.out_free) begin
          cmd_o.op = sitda_pkg::OP_NL;
          state_d  = sitda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sitda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/sitda_dp.sv =====
module sitda_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  sitda_pkg::cmd_t        cmd_i,
  output sitda_pkg::sts_t        sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [6:0]             out_char_o,
  output logic                   out_last_o
);

  // decimal digits of 2^(VALUE_WIDTH-1), with margin
  localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NB   = 4 * NDIG;
  localparam int BCW  = $clog2(VALUE_WIDTH + 1);
  localparam int DCW  = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic [NB-1:0]          bcd_q, bcd_d;
  logic [NB-1:0]          bcd_adj;
  logic [BCW-1:0]         bcnt_q, bcnt_d;
  logic [DCW-1:0]         dcnt_q, dcnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [6:0]             out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;
  logic [3:0]             top_dig;
  logic                   in_neg;

  assign top_dig = bcd_q[NB-1 -: 4];
  assign in_neg  = value_i[VALUE_WIDTH-1];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= sitda_pkg::BCD_ADJ_MIN) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + sitda_pkg::BCD_ADJ;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign sts_o.neg       = neg_q;
  assign sts_o.conv_last = (bcnt_q == BCW'(1));
  assign sts_o.top_zero  = (top_dig == 4'd0);
  assign sts_o.dig_last  = (dcnt_q == DCW'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    mag_d       = mag_q;
    neg_d       = neg_q;
    bcd_d       = bcd_q;
    bcnt_d      = bcnt_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (cmd_i.op)
      sitda_pkg::OP_LOAD: begin
        // two's complement negate; the most negative value lands on 2^(W-1)
        mag_d  = in_neg ? (~value_i + VALUE_WIDTH'(1)) : value_i;
        neg_d  = in_neg;
        bcd_d  = '0;
        bcnt_d = BCW'(VALUE_WIDTH);
        dcnt_d = DCW'(NDIG);
      end
      sitda_pkg::OP_CONV: begin
        bcd_d  = {bcd_adj[NB-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d  = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        bcnt_d = bcnt_q - BCW'(1);
      end
      sitda_pkg::OP_SKIP: begin
        bcd_d  = {bcd_q[NB-5:0], 4'd0};
        dcnt_d = dcnt_q - DCW'(1);
      end
      sitda_pkg::OP_SIGN: begin
        out_valid_d = 1'b1;
        out_char_d  = sitda_pkg::CH_MINUS;
        out_last_d  = 1'b0;
      end
      sitda_pkg::OP_DIGIT: begin
        out_valid_d = 1'b1;
        out_char_d  = sitda_pkg::CH_ZERO + {3'd0, top_dig};
        out_last_d  = 1'b0;
        bcd_d       = {bcd_q[NB-5:0], 4'd0};
        dcnt_d      = dcnt_q - DCW'(1);
      end
      sitda_pkg::OP_NL: begin
        out_valid_d = 1'b1;
        out_char_d  = sitda_pkg::CH_NL;
        out_last_d  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    bcd_q      <= bcd_d;
    bcnt_q     <= bcnt_d;
    dcnt_q     <= dcnt_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== sv/signed_int_to_decimal_ascii_unit.sv =====
// Signed integer to decimal ASCII text.
//
// Slave channel: one item per integer, value in the low VALUE_WIDTH bits of
// s_axis_tdata_i (two's complement). Master channel: one item per character,
// the ASCII code in m_axis_tdata_o[6:0]; a run is an optional '-', the
// decimal digits most significant first without leading zeros, and a
// newline flagged by m_axis_tlast_o.
//
// Sequence: the accept cycle loads the magnitude; a double-dabble converter
// then shifts one bit per cycle, a sign step follows, each of the ten digit
// slots (for 32 bits) is a step of its own whether dropped as leading zeros
// or sent, a turn from skipping to sending follows, and the newline ends the
// item. Every item passes through these steps whatever its sign and digit
// count; sending waits while the output register is full.
// The input is ready only while the controller is idle; it opens again as
// soon as the newline sits in the output register, so the next integer
// starts converting while that newline waits.
// A stall on the master side holds the current character and freezes the
// emission, nothing is lost. Reset empties the output register and returns
// the controller to idle; no other state survives between items.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,  // [W-1:0] value
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [7:0]                           m_axis_tdata_o,  // [6:0] character
  output logic                                 m_axis_tlast_o   // last
);

  sitda_pkg::cmd_t cmd;
  sitda_pkg::sts_t sts;
  logic [6:0]      out_char;

  // sequencing of load, conversion, sign, zero skip, digits and newline
  sitda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // magnitude shifter, BCD register and output register
  sitda_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o)
  );

  // pad the character to a whole byte
  assign m_axis_tdata_o = {1'b0, out_char};

endmodule

// ===== sv/sitda_chk.sv =====
module sitda_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // one integer at a time: busy right after an input item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after accept");

  // the run closes with a newline and only there
  a_last_is_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tlast_o == (m_axis_tdata_o == {1'b0, sitda_pkg::CH_NL})))
    else $error("newline and last flag disagree");

  // every character is a minus, a digit or the newline
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o == {1'b0, sitda_pkg::CH_MINUS}) ||
      (m_axis_tdata_o == {1'b0, sitda_pkg::CH_NL}) ||
      ((m_axis_tdata_o >= {1'b0, sitda_pkg::CH_ZERO}) &&
       (m_axis_tdata_o <= {1'b0, sitda_pkg::CH_ZERO} + 8'd9)))
    else $error("illegal character");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_chk u_sitda_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
